>>> src/dhv_pkg.sv
`timescale 1ns / 1ps

package dhv_pkg;

	localparam logic [7:0] ChM     = 8'h4D;
	localparam logic [7:0] ChP     = 8'h50;
	localparam logic [7:0] ChThree = 8'h33;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChV     = 8'h56;
	localparam logic [7:0] ChDot   = 8'h2E;
	localparam logic [7:0] ChNl    = 8'h0A;
	localparam logic [7:0] ChB     = 8'h42;
	localparam logic [7:0] ChR     = 8'h52;
	localparam logic [7:0] ChT     = 8'h54;
	localparam logic [7:0] ChNul   = 8'h00;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	typedef enum logic [18:0] {
		ST_START = 19'h00001,
		ST_M     = 19'h00002,
		ST_P     = 19'h00004,
		ST_THREE = 19'h00008,
		ST_P2    = 19'h00010,
		ST_SPACE = 19'h00020,
		ST_V     = 19'h00040,
		ST_MAJOR = 19'h00080,
		ST_DOT   = 19'h00100,
		ST_MINOR = 19'h00200,
		ST_NL1   = 19'h00400,
		ST_ID    = 19'h00800,
		ST_NL2   = 19'h01000,
		ST_PW    = 19'h02000,
		ST_NL3   = 19'h04000,
		ST_B     = 19'h08000,
		ST_CMD   = 19'h10000,
		ST_OK    = 19'h20000,
		ST_ERR   = 19'h40000
	} parse_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	// one parsed beat handed to the result stage
	typedef struct packed {
		logic fire;
		logic last_byte;
		logic accepted;
	} parse_res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ChZero) && (c <= ChNine);
	endfunction

endpackage

>>> src/dhv_ifs.sv
`timescale 1ns / 1ps

interface dhv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dhv_out_if;
	logic valid;
	logic ready;
	logic accepted;

	modport source (output valid, output accepted, input ready);
	modport sink (input valid, input accepted, output ready);
endinterface

>>> src/dhv_parser.sv
`timescale 1ns / 1ps

module dhv_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  dhv_pkg::beat_t      beat,
	output dhv_pkg::parse_res_t res
);

	dhv_pkg::parse_state_t state_q;
	dhv_pkg::parse_state_t nxt;
	logic [7:0] c;

	assign c = beat.data_byte;

	always_comb begin
		unique case (state_q)
			dhv_pkg::ST_START: nxt = (c == dhv_pkg::ChM) ? dhv_pkg::ST_M : dhv_pkg::ST_ERR;
			dhv_pkg::ST_M:     nxt = (c == dhv_pkg::ChP) ? dhv_pkg::ST_P : dhv_pkg::ST_ERR;
			dhv_pkg::ST_P:     nxt = (c == dhv_pkg::ChThree) ? dhv_pkg::ST_THREE
			                                                : dhv_pkg::ST_ERR;
			dhv_pkg::ST_THREE: nxt = (c == dhv_pkg::ChP) ? dhv_pkg::ST_P2 : dhv_pkg::ST_ERR;
			dhv_pkg::ST_P2:    nxt = (c == dhv_pkg::ChSpace) ? dhv_pkg::ST_SPACE
			                                                : dhv_pkg::ST_ERR;
			dhv_pkg::ST_SPACE: nxt = (c == dhv_pkg::ChV) ? dhv_pkg::ST_V : dhv_pkg::ST_ERR;
			dhv_pkg::ST_V:     nxt = dhv_pkg::is_digit(c) ? dhv_pkg::ST_MAJOR : dhv_pkg::ST_ERR;
			dhv_pkg::ST_MAJOR: begin
				if (dhv_pkg::is_digit(c)) begin
					nxt = dhv_pkg::ST_MAJOR;
				end else begin
					nxt = (c == dhv_pkg::ChDot) ? dhv_pkg::ST_DOT : dhv_pkg::ST_ERR;
				end
			end
			dhv_pkg::ST_DOT:   nxt = dhv_pkg::is_digit(c) ? dhv_pkg::ST_MINOR : dhv_pkg::ST_ERR;
			dhv_pkg::ST_MINOR: nxt = (c == dhv_pkg::ChNl) ? dhv_pkg::ST_NL1 : dhv_pkg::ST_ERR;
			dhv_pkg::ST_NL1:   nxt = (c != dhv_pkg::ChNl) ? dhv_pkg::ST_ID : dhv_pkg::ST_ERR;
			dhv_pkg::ST_ID:    nxt = (c == dhv_pkg::ChNl) ? dhv_pkg::ST_NL2 : dhv_pkg::ST_ID;
			dhv_pkg::ST_NL2:   nxt = (c != dhv_pkg::ChNl) ? dhv_pkg::ST_PW : dhv_pkg::ST_ERR;
			dhv_pkg::ST_PW:    nxt = (c == dhv_pkg::ChNl) ? dhv_pkg::ST_NL3 : dhv_pkg::ST_PW;
			dhv_pkg::ST_NL3:   nxt = (c == dhv_pkg::ChB) ? dhv_pkg::ST_B : dhv_pkg::ST_ERR;
			dhv_pkg::ST_B:     nxt = (c == dhv_pkg::ChR || c == dhv_pkg::ChT) ? dhv_pkg::ST_CMD
			                                                                 : dhv_pkg::ST_ERR;
			dhv_pkg::ST_CMD:   nxt = (c == dhv_pkg::ChNul) ? dhv_pkg::ST_OK : dhv_pkg::ST_ERR;
			default:           nxt = dhv_pkg::ST_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhv_pkg::ST_START;
		end else if (fire) begin
			// last beat closes the datagram: rewind for the next one
			state_q <= beat.last_byte ? dhv_pkg::ST_START : nxt;
		end
	end

	assign res.fire      = fire;
	assign res.last_byte = beat.last_byte;
	assign res.accepted  = (nxt == dhv_pkg::ST_OK);

endmodule

>>> src/dhv_result.sv
`timescale 1ns / 1ps

module dhv_result (
	input  logic                clk,
	input  logic                arst_n,
	input  dhv_pkg::parse_res_t res,
	output logic                full,
	dhv_out_if.source           out
);

	logic valid_q;
	logic accepted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.fire && res.last_byte) begin
			valid_q <= 1'b1;
		end else if (out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fire && res.last_byte) begin
			accepted_q <= res.accepted;
		end
	end

	// a held result blocks a new one unless it leaves in the same cycle
	assign full         = valid_q && !out.ready;
	assign out.valid    = valid_q;
	assign out.accepted = accepted_q;

endmodule

>>> src/datagram_header_validator.sv
`timescale 1ns / 1ps

// channel | dir | payload              | beat when
// in      | in  | data_byte, last_byte | in.valid && in.ready
// out     | out | accepted             | out.valid && out.ready
//
// One byte per cycle unless a last byte meets a held verdict; a byte waits in the
// input register, and the verdict appears in the result register the cycle after
// the last byte is parsed. Reset (arst_n low) empties both registers and puts the
// parser at the start state. A waiting verdict stalls the input register only when
// it holds another last byte; ordinary bytes keep flowing while out.ready is low.

module datagram_header_validator (
	input  logic      clk,
	input  logic      arst_n,
	dhv_in_if.sink    in,
	dhv_out_if.source out
);

	logic                valid_s1;
	dhv_pkg::beat_t      beat_s1;
	logic                full;
	logic                fire;
	dhv_pkg::parse_res_t res;

	assign fire     = valid_s1 && !(beat_s1.last_byte && full);
	assign in.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			beat_s1.data_byte <= in.data_byte;
			beat_s1.last_byte <= in.last_byte;
		end
	end

	dhv_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.beat   (beat_s1),
		.res    (res)
	);

	dhv_result u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.full   (full),
		.out    (out)
	);

endmodule

>>> sim/datagram_verdict_checker.sv
`timescale 1ns / 1ps

module datagram_verdict_checker
	import dhv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	dhv_in_if    in_ch,
	dhv_out_if   out_ch,
	output int   mismatches,
	output int   pending,
	output int   verdicts,
	output int   accepts
);

	parse_state_t parse_st;
	logic         verdict_q[$];

	function automatic parse_state_t advance_parse(parse_state_t s, logic [7:0] c);
		logic digit;
		digit = (c >= ChZero) && (c <= ChNine);
		case (s)
			ST_START: return (c == ChM) ? ST_M : ST_ERR;
			ST_M:     return (c == ChP) ? ST_P : ST_ERR;
			ST_P:     return (c == ChThree) ? ST_THREE : ST_ERR;
			ST_THREE: return (c == ChP) ? ST_P2 : ST_ERR;
			ST_P2:    return (c == ChSpace) ? ST_SPACE : ST_ERR;
			ST_SPACE: return (c == ChV) ? ST_V : ST_ERR;
			ST_V:     return digit ? ST_MAJOR : ST_ERR;
			ST_MAJOR: return digit ? ST_MAJOR : ((c == ChDot) ? ST_DOT : ST_ERR);
			ST_DOT:   return digit ? ST_MINOR : ST_ERR;
			ST_MINOR: return (c == ChNl) ? ST_NL1 : ST_ERR;
			ST_NL1:   return (c != ChNl) ? ST_ID : ST_ERR;
			ST_ID:    return (c == ChNl) ? ST_NL2 : ST_ID;
			ST_NL2:   return (c != ChNl) ? ST_PW : ST_ERR;
			ST_PW:    return (c == ChNl) ? ST_NL3 : ST_PW;
			ST_NL3:   return (c == ChB) ? ST_B : ST_ERR;
			ST_B:     return (c == ChR || c == ChT) ? ST_CMD : ST_ERR;
			ST_CMD:   return (c == ChNul) ? ST_OK : ST_ERR;
			default:  return ST_ERR;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_st = ST_START;
			verdict_q.delete();
			mismatches = 0;
			verdicts = 0;
			accepts = 0;
		end else begin
			// results always trail their last byte, so take the out beat first
			if (out_ch.valid && out_ch.ready) begin
				verdicts++;
				if (out_ch.accepted)
					accepts++;
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: verdict with none pending: accepted=%0b",
							$realtime, out_ch.accepted);
				end else if (out_ch.accepted !== verdict_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: verdict %0d: expected accepted=%0b, got %0b",
							$realtime, verdicts, verdict_q[0], out_ch.accepted);
					void'(verdict_q.pop_front());
				end else begin
					void'(verdict_q.pop_front());
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				parse_st = advance_parse(parse_st, in_ch.data_byte);
				if (in_ch.last_byte) begin
					verdict_q.push_back(parse_st == ST_OK);
					parse_st = ST_START;
				end
			end
		end
		pending = verdict_q.size();
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import dhv_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 16;

	logic clk;
	logic arst_n;
	int   idle_in_pct;
	int   idle_out_pct;
	int   hold_cycles;
	int   cycle_cnt;
	int   bytes_sent;
	int   datagrams_sent;
	int   mismatches;
	int   pending;
	int   verdicts;
	int   accepts;

	dhv_in_if  in_ch ();
	dhv_out_if out_ch ();

	datagram_header_validator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch)
	);

	datagram_verdict_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.verdicts   (verdicts),
		.accepts    (accepts)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d verdicts pending", cycle_cnt, pending);
			$display("[datagram_header_validator] ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_ch.ready <= 1'b0;
			hold_cycles--;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= idle_out_pct);
		end
	end

	function automatic logic [7:0] rand_digit();
		return ChZero + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_line_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == ChNl);
		return b;
	endfunction

	function automatic void add_tag(ref logic [7:0] q[$]);
		q.push_back(ChM);
		q.push_back(ChP);
		q.push_back(ChThree);
		q.push_back(ChP);
		q.push_back(ChSpace);
	endfunction

	function automatic void add_text(ref logic [7:0] q[$], input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endfunction

	function automatic void add_good(ref logic [7:0] q[$], input int major_len,
		input int id_len);
		add_tag(q);
		q.push_back(ChV);
		repeat (major_len) q.push_back(rand_digit());
		q.push_back(ChDot);
		q.push_back(rand_digit());
		q.push_back(ChNl);
		repeat (id_len) q.push_back(rand_line_byte());
		q.push_back(ChNl);
		repeat ($urandom_range(1, 4)) q.push_back(rand_line_byte());
		q.push_back(ChNl);
		q.push_back(ChB);
		q.push_back($urandom_range(1) ? ChR : ChT);
		q.push_back(ChNul);
	endfunction

	// called just after a rising edge; returns at the edge that takes the beat
	task automatic send_beat(input logic [7:0] b, input logic last);
		logic rdy;
		while ($urandom_range(99) < idle_in_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= 8'($urandom_range(255));
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= last;
		do begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
		end while (!rdy);
		bytes_sent++;
	endtask

	task automatic send_datagram(ref logic [7:0] q[$]);
		for (int i = 0; i < q.size(); i++)
			send_beat(q[i], i == q.size() - 1);
		datagrams_sent++;
		q.delete();
	endtask

	task automatic wait_verdicts();
		in_ch.valid <= 1'b0;
		// let the checker count the beat taken at this edge before testing
		@(negedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic send_random_datagram();
		logic [7:0] q[$];
		int         kind;
		int         keep;
		kind = $urandom_range(99);
		add_good(q, $urandom_range(1, 3), $urandom_range(1, 4));
		if (kind >= 60 && kind < 80) begin
			q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
		end else if (kind >= 80 && kind < 88) begin
			keep = $urandom_range(1, q.size() - 1);
			while (q.size() > keep) void'(q.pop_back());
		end else if (kind >= 88 && kind < 94) begin
			repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(255)));
		end else if (kind >= 94) begin
			q.delete();
			repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
		end
		send_datagram(q);
	endtask

	initial begin
		logic [7:0] dg[$];

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		idle_in_pct = 16;
		idle_out_pct = 85;
		hold_cycles = 0;
		cycle_cnt = 0;
		bytes_sent = 0;
		datagrams_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// id of 0xFF, password of 0x00, lowest and highest digit
		add_tag(dg);
		add_text(dg, "V0.9\n");
		dg.push_back(8'hFF);
		dg.push_back(ChNl);
		dg.push_back(ChNul);
		dg.push_back(ChNl);
		add_text(dg, "BR");
		dg.push_back(ChNul);
		send_datagram(dg);
		// multi-digit major, T command
		add_tag(dg);
		add_text(dg, "V9870.0\nid\npw\nBT");
		dg.push_back(ChNul);
		send_datagram(dg);
		// empty id line, empty password line
		add_tag(dg);
		add_text(dg, "V1.2\n\nx\nBR");
		dg.push_back(ChNul);
		send_datagram(dg);
		add_tag(dg);
		add_text(dg, "V1.2\nx\n\nBR");
		dg.push_back(ChNul);
		send_datagram(dg);
		// two digits after the dot, no major digit, chars just outside the digit range
		add_tag(dg);
		add_text(dg, "V1.23\na\nb\nBR");
		dg.push_back(ChNul);
		send_datagram(dg);
		add_tag(dg);
		add_text(dg, "V.0\na\nb\nBR");
		dg.push_back(ChNul);
		send_datagram(dg);
		add_tag(dg);
		add_text(dg, "V:./\na\nb\nBR");
		dg.push_back(ChNul);
		send_datagram(dg);
		// bad command letter, missing zero byte
		add_tag(dg);
		add_text(dg, "V1.0\na\nb\nBX");
		dg.push_back(ChNul);
		send_datagram(dg);
		add_tag(dg);
		add_text(dg, "V1.0\na\nb\nBR");
		send_datagram(dg);
		// byte after the zero byte
		add_good(dg, 1, 1);
		dg.push_back(8'h41);
		send_datagram(dg);
		// datagram ends after its first byte
		dg.push_back(ChM);
		send_datagram(dg);
		// error latched on the first byte, rest well formed
		dg.push_back(8'h58);
		add_good(dg, 2, 3);
		send_datagram(dg);
		add_good(dg, 1, 1);
		send_datagram(dg);

		for (int phase = 0; phase < 3; phase++) begin
			wait_verdicts();
			idle_in_pct = (phase == 0) ? 16 : (phase == 1) ? 85 : 0;
			idle_out_pct = (phase == 0) ? 85 : (phase == 1) ? 16 : 0;
			if (phase == 2) begin
				// stall the output for a long stretch while single-byte datagrams pile up
				hold_cycles = 300;
				repeat (60) begin
					dg.push_back(8'($urandom_range(255)));
					send_datagram(dg);
				end
				wait_verdicts();
			end
			while (bytes_sent < 550 * (phase + 1))
				send_random_datagram();
		end

		wait_verdicts();
		repeat (DrainCycles) @(posedge clk);
		$display("sent %0d bytes in %0d datagrams: layout extremes, truncation, trailing",
			bytes_sent, datagrams_sent);
		$display("bytes, latched errors and noise; %0d verdicts checked, %0d accepted",
			verdicts, accepts);
		if (mismatches == 0 && pending == 0) begin
			$display("[datagram_header_validator] OK");
		end else begin
			$display("%0d mismatches, %0d verdicts never arrived", mismatches, pending);
			$display("[datagram_header_validator] ERROR");
		end
		$finish;
	end

endmodule
